// ===== sv/rpm_pkg.sv =====
package rpm_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int WINDOW_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    FMT_S8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S32 = 3'd2,
    FMT_U8  = 3'd3,
    FMT_U16 = 3'd4,
    FMT_U32 = 3'd5
  } fmt_e;

  typedef enum logic [1:0] {
    CFG_FORMAT   = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_WINDOW   = 2'd2
  } cfg_idx_e;

  localparam logic [2:0]  FORMAT_RST   = 3'd1;
  localparam logic [3:0]  CHANNELS_RST = 4'd2;
  localparam logic [15:0] WINDOW_RST   = 16'd4800;

  typedef struct packed {
    logic [2:0]  sample_format;
    logic [3:0]  channel_count;
    logic [15:0] window_frames;
  } cfg_t;

  // one classified sample on its way to the accumulators
  typedef struct packed {
    logic [47:0] sq;
    logic [23:0] mag;
    logic        is_left;
    logic        is_right;
    logic        wend;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LAUNCH,
    BK_WAIT,
    BK_PUT
  } back_state_e;

  typedef enum logic [2:0] {
    LV_IDLE,
    LV_DIV,
    LV_NORM,
    LV_LOG,
    LV_MUL,
    LV_RND,
    LV_DONE
  } lvl_state_e;

  localparam logic signed [15:0] DB_FLOOR  = -16'sd25600;
  localparam logic signed [15:0] DB_CEIL   = 16'sd256;
  localparam logic signed [26:0] DB_K      = 27'sd50504453;
  localparam logic [63:0]        REF_LEVEL = 64'd8388352;

  // log2 in q16: integer part in the top six bits, fraction by squaring
  function automatic logic [21:0] log2q16_f(input logic [63:0] x);
    logic [5:0]  n;
    logic [63:0] y;
    logic [15:0] frac;
    n    = 6'd0;
    frac = 16'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 6'(i);
    end
    if (n >= 6'd30) y = x >> (n - 6'd30);
    else y = x << (6'd30 - n);
    for (int i = 0; i < 16; i++) begin
      y    = (y * y) >> 30;
      frac = {frac[14:0], 1'b0};
      if (y >= 64'h8000_0000) begin
        y       = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return {n, frac};
  endfunction

  localparam logic [21:0] REF_LOG = log2q16_f(REF_LEVEL * REF_LEVEL);

endpackage

// ===== sv/rpm_if.sv =====
interface rpm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface rpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_rms_db;
  logic signed [15:0] left_peak_db;
  logic signed [15:0] right_rms_db;
  logic signed [15:0] right_peak_db;
  modport source(output valid, output left_rms_db, output left_peak_db,
                 output right_rms_db, output right_peak_db, input ready);
  modport sink(input valid, input left_rms_db, input left_peak_db,
               input right_rms_db, input right_peak_db, output ready);
endinterface

// ===== sv/rpm_fifo.sv =====
module rpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    if (do_pop) rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end
endmodule

// ===== sv/rpm_front.sv =====
module rpm_front #(
  parameter int MAX_CHANNELS = 8,
  parameter int WINDOW_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rpm_pkg::cfg_t cfg_i,
  rpm_in_if.sink        in_ch,
  output logic          push_o,
  output rpm_pkg::item_t item_o,
  input  logic          full_i
);
  import rpm_pkg::*;

  localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic                   acc;
  logic [PW-1:0]          pos_q, pos_d;
  logic [WINDOW_BITS-1:0] fc_q, fc_d, fc_eff, target;
  logic [31:0]            win32;
  logic [4:0]             count, pos_next;
  logic                   frame_end, wend;
  logic                   hv_q, hv_d;
  logic signed [23:0]     s_d, s_q;
  logic                   tl_q, tr_q, tw_q;
  logic [15:0]            v16;
  logic [31:0]            u32;
  logic [40:0]            m, prod;
  logic [24:0]            q0, q1, q;
  logic [41:0]            r;
  logic [1:0]             adj;
  logic [23:0]            mag;

  assign in_ch.ready = !hv_q || !full_i;
  assign acc         = in_ch.valid && in_ch.ready;
  assign push_o      = hv_q && !full_i;

  // channel and window bookkeeping
  always_comb begin
    if (cfg_i.channel_count == 4'd0) count = 5'd1;
    else if (5'(cfg_i.channel_count) > 5'(MAX_CHANNELS)) count = 5'(MAX_CHANNELS);
    else count = 5'(cfg_i.channel_count);
    pos_next  = 5'(pos_q) + 5'd1;
    frame_end = (pos_next >= count);
    win32     = 32'(cfg_i.window_frames);
    target    = win32[WINDOW_BITS-1:0];
    fc_eff    = (pos_q == '0) ? fc_q + 1'b1 : fc_q;
    wend      = frame_end && (fc_eff == target);
    fc_d      = wend ? '0 : fc_eff;
    pos_d     = frame_end ? '0 : PW'(pos_next);
  end

  // rescale to q16.8
  always_comb begin
    v16  = in_ch.sample[15:0];
    u32  = in_ch.sample;
    m    = '0;
    q0   = '0;
    q1   = '0;
    prod = '0;
    r    = '0;
    adj  = '0;
    q    = '0;
    case (fmt_e'(cfg_i.sample_format))
      FMT_S8:  s_d = {in_ch.sample[7:0], in_ch.sample[7:0] ^ 8'h80, 8'h00};
      FMT_U8:  s_d = {in_ch.sample[7:0] ^ 8'h80, in_ch.sample[7:0], 8'h00};
      FMT_U16: s_d = {v16 ^ 16'h8000, 8'h00};
      FMT_S32, FMT_U32: begin
        if (fmt_e'(cfg_i.sample_format) == FMT_S32) u32 = in_ch.sample ^ 32'h8000_0000;
        // rounded u * 256 / 65537 as floor((u * 256 + 32768) / 65537)
        m    = {1'b0, u32, 8'h00} + 41'd32768;
        q0   = m[40:16] - 25'(m[40:32]);
        q1   = (q0 == '0) ? '0 : q0 - 25'd1;
        prod = {q1, 16'h0000} + 41'(q1);
        r    = 42'(m) - 42'(prod);
        adj  = 2'(r >= 42'd65537) + 2'(r >= 42'd131074) + 2'(r >= 42'd196611);
        q    = q1 + 25'(adj);
        s_d  = {~q[23], q[22:0]};
      end
      default: s_d = {v16, 8'h00};
    endcase
  end

  always_comb begin
    hv_d = hv_q;
    if (acc) hv_d = 1'b1;
    else if (push_o) hv_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b0;
      pos_q <= '0;
      fc_q  <= '0;
    end else begin
      hv_q <= hv_d;
      if (acc) begin
        pos_q <= pos_d;
        fc_q  <= fc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s_q  <= s_d;
      tl_q <= (pos_q == '0);
      tr_q <= (5'(pos_q) == 5'd1);
      tw_q <= wend;
    end
  end

  assign mag = s_q[23] ? 24'(-s_q) : 24'(s_q);

  always_comb begin
    item_o.sq       = 48'(mag) * 48'(mag);
    item_o.mag      = mag;
    item_o.is_left  = tl_q;
    item_o.is_right = tr_q;
    item_o.wend     = tw_q;
  end
endmodule

// ===== sv/rpm_level.sv =====
module rpm_level #(
  parameter int WINDOW_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [63:0]          value_i,
  input  logic [WINDOW_BITS:0] divisor_i,
  output logic                 done_o,
  output logic signed [15:0]   result_o
);
  import rpm_pkg::*;

  localparam int DW = WINDOW_BITS + 1;

  lvl_state_e         st_q, st_d;
  logic [63:0]        quo_q;
  logic [DW-1:0]      rem_q, div_q, rem_step;
  logic [DW:0]        shifted;
  logic               ge;
  logic [5:0]         cnt_q, n_q;
  logic [30:0]        y_q, y_step;
  logic [61:0]        y2;
  logic [31:0]        t;
  logic [15:0]        frac_q;
  logic               zero_q;
  logic signed [23:0] d;
  logic signed [50:0] p_q;
  logic [50:0]        pmag, psum;
  logic [18:0]        r19;
  logic signed [15:0] res_q, res_d;

  always_comb begin
    shifted  = {rem_q, quo_q[63]};
    ge       = (shifted >= {1'b0, div_q});
    rem_step = ge ? DW'(shifted - {1'b0, div_q}) : shifted[DW-1:0];
    y2       = 62'(y_q) * 62'(y_q);
    t        = y2[61:30];
    y_step   = t[31] ? t[31:1] : t[30:0];
    d        = $signed({2'b00, n_q, frac_q}) - $signed({2'b00, REF_LOG});
    pmag     = p_q[50] ? 51'(-p_q) : 51'(p_q);
    psum     = pmag + (51'd1 << 31);
    r19      = psum[50:32];
    if (zero_q) res_d = DB_FLOOR;
    else if (p_q[50]) res_d = (r19 > 19'd25600) ? DB_FLOOR : -$signed(16'(r19));
    else res_d = (r19 > 19'd256) ? DB_CEIL : $signed(16'(r19));
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      LV_IDLE: if (start_i) st_d = LV_DIV;
      LV_DIV:  if (cnt_q == 6'd63) st_d = LV_NORM;
      LV_NORM: begin
        if (quo_q == '0) st_d = LV_RND;
        else if (quo_q[63]) st_d = LV_LOG;
      end
      LV_LOG:  if (cnt_q[3:0] == 4'd15) st_d = LV_MUL;
      LV_MUL:  st_d = LV_RND;
      LV_RND:  st_d = LV_DONE;
      LV_DONE: st_d = LV_IDLE;
      default: st_d = LV_IDLE;
    endcase
  end

  always_comb begin
    done_o   = (st_q == LV_DONE);
    result_o = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= LV_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      LV_IDLE: begin
        quo_q  <= value_i;
        div_q  <= divisor_i;
        rem_q  <= '0;
        cnt_q  <= '0;
        n_q    <= 6'd63;
        frac_q <= '0;
        zero_q <= 1'b0;
      end
      LV_DIV: begin
        rem_q <= rem_step;
        quo_q <= {quo_q[62:0], ge};
        cnt_q <= cnt_q + 6'd1;
      end
      LV_NORM: begin
        cnt_q <= '0;
        if (quo_q == '0) zero_q <= 1'b1;
        else if (quo_q[63]) y_q <= quo_q[63:33];
        else begin
          quo_q <= {quo_q[62:0], 1'b0};
          n_q   <= n_q - 6'd1;
        end
      end
      LV_LOG: begin
        y_q    <= y_step;
        frac_q <= {frac_q[14:0], t[31]};
        cnt_q  <= cnt_q + 6'd1;
      end
      LV_MUL:  p_q <= 51'(d) * 51'(DB_K);
      LV_RND:  res_q <= res_d;
      default: ;
    endcase
  end
endmodule

// ===== sv/rpm_back.sv =====
module rpm_back #(
  parameter int WINDOW_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  rpm_pkg::item_t       item_i,
  output logic                 pop_o,
  input  logic [WINDOW_BITS:0] divisor_i,
  rpm_out_if.source            out_ch
);
  import rpm_pkg::*;

  back_state_e        st_q, st_d;
  logic [1:0]         k_q;
  logic [63:0]        lsum_q, rsum_q, lsum_s, rsum_s, lsum_n, rsum_n;
  logic [23:0]        lpk_q, rpk_q, lpk_s, rpk_s, lpk_n, rpk_n;
  logic [64:0]        ladd, radd;
  logic signed [15:0] res_q [4];
  logic               ov_q;
  logic               lv_start, lv_done;
  logic [63:0]        lv_value;
  logic [WINDOW_BITS:0] lv_div;
  logic signed [15:0] lv_res;

  rpm_level #(.WINDOW_BITS(WINDOW_BITS)) u_level (
    .clk_i, .rst_ni,
    .start_i(lv_start), .value_i(lv_value), .divisor_i(lv_div),
    .done_o(lv_done), .result_o(lv_res)
  );

  // accumulate with saturation
  always_comb begin
    ladd   = {1'b0, lsum_q} + 65'(item_i.sq);
    radd   = {1'b0, rsum_q} + 65'(item_i.sq);
    lsum_n = lsum_q;
    rsum_n = rsum_q;
    lpk_n  = lpk_q;
    rpk_n  = rpk_q;
    if (item_i.is_left) begin
      lsum_n = ladd[64] ? '1 : ladd[63:0];
      if (item_i.mag > lpk_q) lpk_n = item_i.mag;
    end
    if (item_i.is_right) begin
      rsum_n = radd[64] ? '1 : radd[63:0];
      if (item_i.mag > rpk_q) rpk_n = item_i.mag;
    end
  end

  // a window end waits until the previous result has left the output register
  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE:   if (valid_i && item_i.wend && !ov_q) st_d = BK_LAUNCH;
      BK_LAUNCH: st_d = BK_WAIT;
      BK_WAIT:   if (lv_done) st_d = (k_q == 2'd3) ? BK_PUT : BK_LAUNCH;
      BK_PUT:    if (!ov_q) st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (st_q == BK_IDLE) && valid_i && !(item_i.wend && ov_q);
    lv_start = (st_q == BK_LAUNCH);
    case (k_q)
      2'd0:    lv_value = lsum_s;
      2'd1:    lv_value = 64'(lpk_s) * 64'(lpk_s);
      2'd2:    lv_value = rsum_s;
      default: lv_value = 64'(rpk_s) * 64'(rpk_s);
    endcase
    lv_div = k_q[0] ? (WINDOW_BITS+1)'(1) : divisor_i;
  end

  assign out_ch.valid         = ov_q;
  assign out_ch.left_rms_db   = res_q[0];
  assign out_ch.left_peak_db  = res_q[1];
  assign out_ch.right_rms_db  = res_q[2];
  assign out_ch.right_peak_db = res_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= BK_IDLE;
      k_q    <= '0;
      ov_q   <= 1'b0;
      lsum_q <= '0;
      rsum_q <= '0;
      lpk_q  <= '0;
      rpk_q  <= '0;
    end else begin
      st_q <= st_d;
      if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
      if (pop_o) begin
        if (item_i.wend) begin
          lsum_q <= '0;
          rsum_q <= '0;
          lpk_q  <= '0;
          rpk_q  <= '0;
          k_q    <= '0;
        end else begin
          lsum_q <= lsum_n;
          rsum_q <= rsum_n;
          lpk_q  <= lpk_n;
          rpk_q  <= rpk_n;
        end
      end
      if (st_q == BK_WAIT && lv_done) k_q <= k_q + 2'd1;
      if (st_q == BK_PUT && !ov_q) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.wend) begin
      lsum_s <= lsum_n;
      rsum_s <= rsum_n;
      lpk_s  <= lpk_n;
      rpk_s  <= rpk_n;
    end
    if (st_q == BK_WAIT && lv_done) res_q[k_q] <= lv_res;
  end
endmodule

// ===== sv/stereo_rms_peak_meter.sv =====
// stereo rms and peak level meter
// in_ch takes one interleaved raw audio sample per transfer; position 0 of
// each frame is left, position 1 is right, further positions only count
// out_ch gives one transfer per completed window: rms and peak of both
// channels in dB relative to full scale, signed q8.8, floored at -100 dB
// the config port writes sample_format, channel_count and window_frames;
// write it only while the meter is idle
// throughput: one sample per cycle while accumulating; the front rescales
// a sample, registers it, squares it and feeds a two-entry queue
// at a window end the back runs four level computations through one shared
// iterative unit: 64 divide steps, up to 63 normalize shifts, 16 log squaring
// steps and three more per computation, before the result transfer; during
// that time the queue fills and in_ch stalls
// a stalled receiver holds the result in the output register; accumulation
// of the next window goes on meanwhile, only the next window end waits
// reset clears all sums, peaks and counters and loads the default config
module stereo_rms_peak_meter #(
  parameter int MAX_CHANNELS = rpm_pkg::MAX_CHANNELS_DEF,
  parameter int WINDOW_BITS  = rpm_pkg::WINDOW_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  rpm_in_if.sink      in_ch,
  rpm_out_if.source   out_ch
);
  import rpm_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  // front to back queue
  item_t front_item, back_item;
  logic  push, full, qvalid, pop;

  // averaging divisor: a zero window means the full counter range
  logic [31:0]          win32;
  logic [WINDOW_BITS:0] divisor;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format <= FORMAT_RST;
      cfg_q.channel_count <= CHANNELS_RST;
      cfg_q.window_frames <= WINDOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FORMAT:   cfg_q.sample_format <= cfg_data_i[2:0];
        CFG_CHANNELS: cfg_q.channel_count <= cfg_data_i[3:0];
        CFG_WINDOW:   cfg_q.window_frames <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_comb begin
    win32 = 32'(cfg_q.window_frames);
    if (win32[WINDOW_BITS-1:0] == '0) divisor = (WINDOW_BITS+1)'(1) << WINDOW_BITS;
    else divisor = {1'b0, win32[WINDOW_BITS-1:0]};
  end

  // front: rescale, square, tag channel and window end
  rpm_front #(.MAX_CHANNELS(MAX_CHANNELS), .WINDOW_BITS(WINDOW_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_ch,
    .push_o(push), .item_o(front_item), .full_i(full)
  );

  rpm_fifo #(.WIDTH($bits(item_t)), .DEPTH(2)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(front_item), .full_o(full),
    .pop_i(pop), .valid_o(qvalid), .data_o(back_item)
  );

  // back: accumulate and compute levels
  rpm_back #(.WINDOW_BITS(WINDOW_BITS)) u_back (
    .clk_i, .rst_ni,
    .valid_i(qvalid), .item_i(back_item), .pop_o(pop),
    .divisor_i(divisor), .out_ch
  );
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rpm_pkg::*;

  localparam int LONG_HOLD = 3000;

  // one result transfer: the four levels of a window
  typedef struct {
    logic signed [15:0] l_rms;
    logic signed [15:0] l_peak;
    logic signed [15:0] r_rms;
    logic signed [15:0] r_peak;
  } levels_t;

  // a row of the directed table: a register write or a sample
  typedef struct {
    bit          is_write;
    cfg_idx_e    idx;
    logic [31:0] value;
    bit          typed;
    levels_t     lv;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  rpm_in_if  in_if();
  rpm_out_if out_if();

  stereo_rms_peak_meter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_if.sink),
    .out_ch     (out_if.source)
  );

  // meter state as seen by the level predictor
  logic [2:0]  m_format   = FORMAT_RST;
  logic [3:0]  m_channels = CHANNELS_RST;
  logic [15:0] m_window   = WINDOW_RST;
  int          m_pos      = 0;
  logic [15:0] m_frames   = '0;
  logic [63:0] m_lsum     = '0;
  logic [63:0] m_rsum     = '0;
  logic [23:0] m_lpeak    = '0;
  logic [23:0] m_rpeak    = '0;

  levels_t pending_levels[$];
  row_t    rows[$];
  int      errors   = 0;
  int      src_idle = 0;  // percent of cycles the sender holds back
  int      snk_stall = 0; // percent of cycles the receiver stalls
  int      hold_cnt = 0;
  logic    hold_kick;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // safety net against a hung handshake
  initial begin
    #100_000_000;
    $display("stereo_rms_peak_meter verification failed");
    $finish;
  end

  // raw sample bits to signed 16.8 full scale
  function automatic int to_fixed(logic [31:0] raw);
    int                x;
    longint unsigned   u;
    case (m_format)
      FMT_S8: begin
        x = int'($signed(raw[7:0]));
        return ((x + 128) * 257 - 32768) * 256;
      end
      FMT_U8: begin
        x = int'(raw[7:0]);
        return (x * 257 - 32768) * 256;
      end
      FMT_U16: begin
        x = int'(raw[15:0]);
        return (x - 32768) * 256;
      end
      FMT_S32, FMT_U32: begin
        u = longint'(raw);
        if (m_format == FMT_S32) u = u ^ 64'h8000_0000;
        return int'(longint'((u * 512 + 65537) / 131074) - 8388608);
      end
      default: return int'($signed(raw[15:0])) * 256;
    endcase
  endfunction

  // log2 in q16: leading one plus 16 fraction bits by squaring the mantissa
  function automatic longint log2_q16(logic [63:0] x);
    int          n;
    logic [63:0] y;
    longint      frac;
    n = 0;
    frac = 0;
    for (int i = 0; i < 64; i++) if (x[i]) n = i;
    y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    return longint'(n) * 65536 + frac;
  endfunction

  function automatic logic signed [15:0] power_db(logic [63:0] pw);
    longint          d;
    longint          p;
    longint          r;
    longint unsigned mag;
    if (pw == 0) return DB_FLOOR;
    d = log2_q16(pw) - log2_q16(64'd8388352 * 64'd8388352);
    p = d * 64'sd50504453;
    mag = (p < 0) ? longint'(-p) : longint'(p);
    r = longint'((mag + 64'h8000_0000) >> 32);
    if (p < 0) r = -r;
    if (r < -25600) r = -25600;
    if (r > 256) r = 256;
    return 16'(r);
  endfunction

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // advance the predicted state by one sample; returns 1 at a window end
  function automatic bit meter_step(logic [31:0] raw, output levels_t lv);
    int          s;
    logic [23:0] mag;
    logic [63:0] sq;
    int          cnt;
    bit          frame_end;
    logic [63:0] div;
    s = to_fixed(raw);
    mag = 24'((s < 0) ? -s : s);
    sq = 64'(mag) * 64'(mag);
    cnt = int'(m_channels);
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_CHANNELS_DEF) cnt = MAX_CHANNELS_DEF;
    if (m_pos == 0) begin
      m_frames = m_frames + 16'd1;
      m_lsum = sum_sat(m_lsum, sq);
      if (mag > m_lpeak) m_lpeak = mag;
    end else if (m_pos == 1) begin
      m_rsum = sum_sat(m_rsum, sq);
      if (mag > m_rpeak) m_rpeak = mag;
    end
    frame_end = (m_pos + 1 >= cnt);
    m_pos = frame_end ? 0 : m_pos + 1;
    if (!frame_end || m_frames != m_window) return 1'b0;
    div = (m_window == 0) ? 64'd65536 : 64'(m_window);
    lv.l_rms  = power_db(m_lsum / div);
    lv.l_peak = power_db(64'(m_lpeak) * 64'(m_lpeak));
    lv.r_rms  = power_db(m_rsum / div);
    lv.r_peak = power_db(64'(m_rpeak) * 64'(m_rpeak));
    m_frames = '0;
    m_lsum = '0;
    m_rsum = '0;
    m_lpeak = '0;
    m_rpeak = '0;
    return 1'b1;
  endfunction

  // long receiver hold-off, counted here so the sender can keep offering
  always @(posedge clk_i) begin
    if (hold_kick) hold_cnt <= LONG_HOLD;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // receiver: check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    levels_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0d %0d %0d %0d", $time,
                 out_if.left_rms_db, out_if.left_peak_db,
                 out_if.right_rms_db, out_if.right_peak_db);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (out_if.left_rms_db !== want.l_rms) begin
          $display("%0t left_rms_db: expected %0d, actual %0d", $time, want.l_rms,
                   out_if.left_rms_db);
          errors++;
        end
        if (out_if.left_peak_db !== want.l_peak) begin
          $display("%0t left_peak_db: expected %0d, actual %0d", $time, want.l_peak,
                   out_if.left_peak_db);
          errors++;
        end
        if (out_if.right_rms_db !== want.r_rms) begin
          $display("%0t right_rms_db: expected %0d, actual %0d", $time, want.r_rms,
                   out_if.right_rms_db);
          errors++;
        end
        if (out_if.right_peak_db !== want.r_peak) begin
          $display("%0t right_peak_db: expected %0d, actual %0d", $time, want.r_peak,
                   out_if.right_peak_db);
          errors++;
        end
      end
    end
    out_if.ready <= rst_ni && (hold_cnt == 0) && ($urandom_range(99) >= snk_stall);
  end

  // offer one sample, wait for its transfer, then run the predictor
  task automatic send_sample(logic [31:0] raw, bit typed, levels_t typed_lv);
    levels_t lv;
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= raw;
    do @(posedge clk_i); while (!in_if.ready);
    if (meter_step(raw, lv)) pending_levels.push_back(typed ? typed_lv : lv);
    else if (typed) pending_levels.push_back(typed_lv);
  endtask

  // wait until every result is in and the back end has gone quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  // run samples until the current window has closed on a frame boundary
  task automatic close_window(inout int cnt);
    levels_t none;
    none = '{default: '0};
    while (m_frames != '0 || m_pos != 0) begin
      send_sample(pick_sample(), 1'b0, none);
      cnt++;
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_FORMAT:   m_format   = value[2:0];
      CFG_CHANNELS: m_channels = value[3:0];
      CFG_WINDOW:   m_window   = value;
      default: ;
    endcase
  endtask

  task automatic row_write(cfg_idx_e idx, logic [15:0] value);
    row_t r;
    r.is_write = 1'b1;
    r.idx = idx;
    r.value = 32'(value);
    r.typed = 1'b0;
    r.lv = '{default: '0};
    rows.push_back(r);
  endtask

  task automatic row_sample(logic [31:0] raw);
    row_t r;
    r.is_write = 1'b0;
    r.idx = CFG_FORMAT;
    r.value = raw;
    r.typed = 1'b0;
    r.lv = '{default: '0};
    rows.push_back(r);
  endtask

  // sample whose window result can be read off at a glance
  task automatic row_known(logic [31:0] raw, logic signed [15:0] lr, logic signed [15:0] lp,
                           logic signed [15:0] rr, logic signed [15:0] rp);
    row_t r;
    r.is_write = 1'b0;
    r.idx = CFG_FORMAT;
    r.value = raw;
    r.typed = 1'b1;
    r.lv = '{lr, lp, rr, rp};
    rows.push_back(r);
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] corner[10] = '{32'h0, 32'h7F, 32'h80, 32'hFF, 32'h7FFF, 32'h8000,
                                32'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(2))
      0: return $urandom;
      1: return corner[$urandom_range(9)];
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  initial begin
    levels_t none;
    int      sent;
    int      phase;
    int      n;
    none = '{default: '0};
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    hold_kick = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: mono and stereo single-frame windows give results at a glance
    row_write(CFG_FORMAT, 16'(FMT_S16));
    row_write(CFG_CHANNELS, 16'd1);
    row_write(CFG_WINDOW, 16'd1);
    row_known(32'h0, DB_FLOOR, DB_FLOOR, DB_FLOOR, DB_FLOOR);
    row_known(32'h7FFF, 16'sd0, 16'sd0, DB_FLOOR, DB_FLOOR);
    row_known(32'h8000, 16'sd0, 16'sd0, DB_FLOOR, DB_FLOOR);
    row_known(32'hFFFF_8000, 16'sd0, 16'sd0, DB_FLOOR, DB_FLOOR);
    row_write(CFG_CHANNELS, 16'd2);
    row_sample(32'h7FFF);
    row_known(32'h0, 16'sd0, 16'sd0, DB_FLOOR, DB_FLOOR);
    row_sample(32'h0);
    row_known(32'h7FFF, DB_FLOOR, DB_FLOOR, 16'sd0, 16'sd0);
    row_write(CFG_FORMAT, 16'(FMT_S8));
    row_sample(32'h7F);
    row_sample(32'h80);
    row_write(CFG_FORMAT, 16'(FMT_U8));
    row_sample(32'hFF);
    row_sample(32'h00);
    row_write(CFG_FORMAT, 16'(FMT_U16));
    row_sample(32'hFFFF);
    row_sample(32'h1);
    row_write(CFG_FORMAT, 16'(FMT_S32));
    row_sample(32'h7FFF_FFFF);
    row_sample(32'h8000_0000);
    row_write(CFG_FORMAT, 16'(FMT_U32));
    row_sample(32'hFFFF_FFFF);
    row_sample(32'h0);
    // unknown format codes fall back to s16
    row_write(CFG_FORMAT, 16'd7);
    row_sample(32'h1234);
    row_sample(32'hC000);
    // zero channels acts as mono, window of three frames
    row_write(CFG_CHANNELS, 16'd0);
    row_write(CFG_WINDOW, 16'd3);
    row_sample(32'h100);
    row_sample(32'h2000);
    row_sample(32'hF000);
    // channel count above the limit, then lowered mid-frame
    row_write(CFG_CHANNELS, 16'd15);
    row_write(CFG_WINDOW, 16'd1);
    for (int i = 0; i < 3; i++) row_sample(32'h4000 + i);
    row_write(CFG_CHANNELS, 16'd2);
    row_sample(32'h7777);

    foreach (rows[i]) begin
      if (rows[i].is_write) write_reg(rows[i].idx, rows[i].value[15:0]);
      else send_sample(rows[i].value, rows[i].typed, rows[i].lv);
    end
    settle();

    // random part: short windows, random formats and counts, rotating idle patterns
    sent = 0;
    phase = 0;
    while (sent < 1400) begin
      close_window(sent);
      write_reg(CFG_FORMAT, 16'($urandom_range(7)));
      write_reg(CFG_CHANNELS, 16'(($urandom_range(9) == 0) ? $urandom_range(15)
                                                              : $urandom_range(1, 3)));
      write_reg(CFG_WINDOW, 16'($urandom_range(1, 6)));
      case (phase % 4)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 83; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 83; end
        default: begin src_idle = 18; snk_stall = 18; end
      endcase
      n = $urandom_range(40, 120);
      if (phase == 2) begin
        // long receiver hold-off while samples keep coming: the meter backs up
        snk_stall = 0;
        hold_kick <= 1'b1;
        @(posedge clk_i);
        hold_kick <= 1'b0;
      end
      repeat (n) send_sample(pick_sample(), 1'b0, none);
      sent += n;
      phase++;
    end
    src_idle = 0;
    snk_stall = 0;

    // widest channel count with two-frame windows
    close_window(sent);
    write_reg(CFG_CHANNELS, 16'd8);
    write_reg(CFG_WINDOW, 16'd2);
    repeat (32) send_sample(pick_sample(), 1'b0, none);
    close_window(sent);

    // window lowered below the frame count: no result until the counter wraps
    write_reg(CFG_FORMAT, 16'(FMT_S16));
    write_reg(CFG_CHANNELS, 16'd1);
    write_reg(CFG_WINDOW, 16'd200);
    repeat (100) send_sample($urandom, 1'b0, none);
    write_reg(CFG_WINDOW, 16'd50);
    repeat (60) send_sample($urandom, 1'b0, none);

    settle();
    if (errors == 0) begin
      $display("stereo_rms_peak_meter verification clean");
    end else begin
      $display("stereo_rms_peak_meter verification failed");
    end
    $finish;
  end

endmodule
